FILE: rtl/core/lsx_pkg.sv
// Shared types, token codes and keyword table for the lexer.
package lsx_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM_INT,
        MODE_NUM_DOT,
        MODE_NUM_FRAC,
        MODE_CHAR_OPEN,
        MODE_CHAR_BODY,
        MODE_LPAREN,
        MODE_COLON,
        MODE_LESS,
        MODE_GREATER,
        MODE_COMMENT,
        MODE_COMMENT_STAR
    } scan_mode_t;

    localparam logic [4:0] K_END    = 5'd0;
    localparam logic [4:0] K_ERROR  = 5'd1;
    localparam logic [4:0] K_IDENT  = 5'd2;
    localparam logic [4:0] K_NUMBER = 5'd3;
    localparam logic [4:0] K_CHAR   = 5'd4;
    localparam logic [4:0] K_ASSIGN = 5'd19;
    localparam logic [4:0] K_COMMA  = 5'd20;
    localparam logic [4:0] K_PERIOD = 5'd21;
    localparam logic [4:0] K_COLON  = 5'd22;
    localparam logic [4:0] K_SEMI   = 5'd23;
    localparam logic [4:0] K_OPEN   = 5'd24;
    localparam logic [4:0] K_CLOSE  = 5'd25;
    localparam logic [4:0] K_REL    = 5'd26;
    localparam logic [4:0] K_ADD    = 5'd27;
    localparam logic [4:0] K_MUL    = 5'd28;

    localparam logic [4:0] LEN_MAX  = 5'd31;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    localparam int KW_COUNT = 20;
    localparam int KW_BYTES = 8;

    localparam logic [8*KW_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
        "program", "var", "begin", "boolean", "char", "integer", "read",
        "write", "if", "else", "then", "while", "do", "not", "true",
        "false", "end", "or", "and", "div"
    };
    localparam logic [4:0] KW_LEN [KW_COUNT] = '{
        5'd7, 5'd3, 5'd5, 5'd7, 5'd4, 5'd7, 5'd4, 5'd5, 5'd2, 5'd4,
        5'd4, 5'd5, 5'd2, 5'd3, 5'd4, 5'd5, 5'd3, 5'd2, 5'd3, 5'd3
    };
    localparam logic [4:0] KW_KIND [KW_COUNT] = '{
        5'd5, 5'd6, 5'd7, 5'd8, 5'd8, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
        5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd17, 5'd18, K_REL, K_REL, K_MUL
    };

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [23:0] offset;
        logic [4:0]  length;
        logic [7:0]  char_value;
        logic        last;
    } token_t;

    function automatic token_t make_token(input logic [4:0] kind, input logic [15:0] line,
                                          input logic [23:0] offset,
                                          input logic [4:0] length,
                                          input logic [7:0] ch);
        token_t t;
        t.kind       = kind;
        t.line       = line;
        t.offset     = offset;
        t.length     = length;
        t.char_value = ch;
        t.last       = 1'b0;
        return t;
    endfunction

    function automatic logic [4:0] sat_inc(input logic [4:0] v);
        return (v == LEN_MAX) ? LEN_MAX : v + 5'd1;
    endfunction

    function automatic logic [4:0] ident_kind(input logic [8*KW_BYTES-1:0] view,
                                              input logic [4:0] len);
        logic [4:0] kind;
        logic       hit;
        int         pos;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (KW_LEN[k] == len);
            for (int j = 0; j < KW_BYTES; j++) begin
                pos = int'(KW_LEN[k]) - 1 - j;
                if (j < int'(KW_LEN[k])
                    && view[j*8 +: 8] != KW_TEXT[k][pos*8 +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                kind = KW_KIND[k];
            end
        end
        return kind;
    endfunction

endpackage

FILE: rtl/core/lsx_scan.sv
// Front scanner: classifies each source byte and forms up to two tokens.
module lsx_scan
    import lsx_pkg::*;
#(
    parameter int MAX_ID_LEN = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] byte_in,
    output logic       tok0_valid,
    output logic       tok1_valid,
    output token_t     tok0,
    output token_t     tok1
);

    scan_mode_t  mode_reg, mode_next;
    logic [15:0] line_reg, line_next;
    logic [23:0] pos_reg;
    logic [23:0] tstart_reg, tstart_next;
    logic [4:0]  len_reg, len_next;
    logic [15:0] sline_reg, sline_next;
    logic [7:0]  held_reg, held_next;
    logic        halt_reg, halt_next;
    logic [7:0]  store_reg [MAX_ID_LEN];

    logic        store_we;
    logic [4:0]  store_idx;
    logic [63:0] view;
    logic        idle_run;
    logic        emit_v;
    token_t      emit_t;
    logic        t0_v, t1_v;
    token_t      t0, t1;
    logic [7:0]  b;
    logic        is_lower, is_digit, is_alpha, is_idch;
    logic [15:0] line_inc;

    for (genvar j = 0; j < KW_BYTES; j++) begin : g_view
        if (j < MAX_ID_LEN) begin : g_have
            assign view[j*8 +: 8] = store_reg[j];
        end else begin : g_pad
            assign view[j*8 +: 8] = 8'd0;
        end
    end

    assign b        = byte_in;
    assign is_lower = b inside {[8'h61:8'h7A]};
    assign is_digit = b inside {[8'h30:8'h39]};
    assign is_alpha = is_lower || (b inside {[8'h41:8'h5A]});
    assign is_idch  = is_alpha || is_digit || (b == 8'h5F);
    assign line_inc = (line_reg == LINE_MAX) ? LINE_MAX : line_reg + 16'd1;

    always_comb
    begin
        mode_next   = mode_reg;
        line_next   = line_reg;
        tstart_next = tstart_reg;
        len_next    = len_reg;
        sline_next  = sline_reg;
        held_next   = held_reg;
        halt_next   = halt_reg;
        store_we    = 1'b0;
        store_idx   = 5'd0;
        idle_run    = 1'b0;
        t0_v        = 1'b0;
        t1_v        = 1'b0;
        t0          = make_token(K_END, line_reg, pos_reg, 5'd0, 8'd0);
        t1          = t0;
        emit_v      = 1'b0;
        emit_t      = t0;

        case (mode_reg)
            MODE_IDENT:
            begin
                if (is_idch) begin
                    if (len_reg < 5'(MAX_ID_LEN)) begin
                        store_we  = 1'b1;
                        store_idx = len_reg;
                        len_next  = len_reg + 5'd1;
                    end else begin
                        t0_v      = 1'b1;
                        t0        = make_token(K_ERROR, sline_reg, tstart_reg,
                                               sat_inc(len_reg), 8'd0);
                        mode_next = MODE_IDLE;
                        halt_next = 1'b1;
                    end
                end else begin
                    t0_v     = 1'b1;
                    t0       = make_token(ident_kind(view, len_reg), sline_reg,
                                          tstart_reg, len_reg, 8'd0);
                    idle_run = 1'b1;
                end
            end
            MODE_NUM_INT, MODE_NUM_FRAC:
            begin
                if (is_digit) begin
                    len_next = sat_inc(len_reg);
                end else if (b == 8'h2E && mode_reg == MODE_NUM_INT) begin
                    len_next  = sat_inc(len_reg);
                    mode_next = MODE_NUM_DOT;
                end else if (is_alpha) begin
                    t0_v      = 1'b1;
                    t0        = make_token(K_ERROR, sline_reg, tstart_reg,
                                           sat_inc(len_reg), 8'd0);
                    mode_next = MODE_IDLE;
                    halt_next = 1'b1;
                end else begin
                    t0_v     = 1'b1;
                    t0       = make_token(K_NUMBER, sline_reg, tstart_reg, len_reg, 8'd0);
                    idle_run = 1'b1;
                end
            end
            MODE_NUM_DOT:
            begin
                if (is_digit) begin
                    len_next  = sat_inc(len_reg);
                    mode_next = MODE_NUM_FRAC;
                end else begin
                    t0_v      = 1'b1;
                    t0        = make_token(K_ERROR, sline_reg, tstart_reg,
                                           sat_inc(len_reg), 8'd0);
                    mode_next = MODE_IDLE;
                    halt_next = 1'b1;
                end
            end
            MODE_CHAR_OPEN:
            begin
                if (b == 8'd0) begin
                    t0_v      = 1'b1;
                    t0        = make_token(K_END, line_reg, pos_reg, 5'd0, 8'd0);
                    mode_next = MODE_IDLE;
                    halt_next = 1'b1;
                end else begin
                    held_next = b;
                    if (b == 8'h0A) begin
                        line_next = line_inc;
                    end
                    len_next  = 5'd2;
                    mode_next = MODE_CHAR_BODY;
                end
            end
            MODE_CHAR_BODY:
            begin
                t0_v      = 1'b1;
                mode_next = MODE_IDLE;
                if (b == 8'h27) begin
                    t0 = make_token(K_CHAR, sline_reg, tstart_reg, 5'd3, held_reg);
                end else begin
                    t0        = make_token(K_ERROR, sline_reg, tstart_reg,
                                           sat_inc(len_reg), 8'd0);
                    halt_next = 1'b1;
                end
            end
            MODE_LPAREN:
            begin
                if (b == 8'h2A) begin
                    mode_next = MODE_COMMENT;
                end else begin
                    t0_v     = 1'b1;
                    t0       = make_token(K_OPEN, sline_reg, tstart_reg, 5'd1, 8'd0);
                    idle_run = 1'b1;
                end
            end
            MODE_COLON:
            begin
                t0_v      = 1'b1;
                mode_next = MODE_IDLE;
                if (b == 8'h3D) begin
                    t0 = make_token(K_ASSIGN, sline_reg, tstart_reg, 5'd2, 8'd0);
                end else begin
                    t0       = make_token(K_COLON, sline_reg, tstart_reg, 5'd1, 8'd0);
                    idle_run = 1'b1;
                end
            end
            MODE_LESS, MODE_GREATER:
            begin
                t0_v      = 1'b1;
                mode_next = MODE_IDLE;
                if (b == 8'h3D || (b == 8'h3E && mode_reg == MODE_LESS)) begin
                    t0 = make_token(K_REL, sline_reg, tstart_reg, 5'd2, 8'd0);
                end else begin
                    t0       = make_token(K_REL, sline_reg, tstart_reg, 5'd1, 8'd0);
                    idle_run = 1'b1;
                end
            end
            MODE_COMMENT, MODE_COMMENT_STAR:
            begin
                if (b == 8'd0) begin
                    t0_v      = 1'b1;
                    t0        = make_token(K_END, line_reg, pos_reg, 5'd0, 8'd0);
                    mode_next = MODE_IDLE;
                    halt_next = 1'b1;
                end else if (b == 8'h29 && mode_reg == MODE_COMMENT_STAR) begin
                    mode_next = MODE_IDLE;
                end else if (b == 8'h2A) begin
                    mode_next = MODE_COMMENT_STAR;
                end else begin
                    if (b == 8'h0A) begin
                        line_next = line_inc;
                    end
                    mode_next = MODE_COMMENT;
                end
            end
            default:
            begin
                idle_run = 1'b1;
            end
        endcase

        if (idle_run) begin
            mode_next = MODE_IDLE;
            emit_t    = make_token(K_ERROR, line_reg, pos_reg, 5'd1, 8'd0);
            if (b == 8'd0) begin
                emit_v    = 1'b1;
                emit_t    = make_token(K_END, line_reg, pos_reg, 5'd0, 8'd0);
                halt_next = 1'b1;
            end else if (b == 8'h20 || b == 8'h09) begin
                emit_v = 1'b0;
            end else if (b == 8'h0A) begin
                line_next = line_inc;
            end else if (is_lower || is_digit || b inside {8'h27, 8'h28, 8'h3A, 8'h3C, 8'h3E})
            begin
                tstart_next = pos_reg;
                sline_next  = line_reg;
                len_next    = 5'd1;
                if (is_lower) begin
                    mode_next = MODE_IDENT;
                    store_we  = 1'b1;
                    store_idx = 5'd0;
                end else if (is_digit) begin
                    mode_next = MODE_NUM_INT;
                end else begin
                    case (b)
                        8'h27:   mode_next = MODE_CHAR_OPEN;
                        8'h28:   mode_next = MODE_LPAREN;
                        8'h3A:   mode_next = MODE_COLON;
                        8'h3C:   mode_next = MODE_LESS;
                        default: mode_next = MODE_GREATER;
                    endcase
                end
            end else if (b == 8'h5F) begin
                tstart_next = pos_reg;
                sline_next  = line_reg;
                len_next    = 5'd1;
                mode_next   = MODE_IDENT;
                store_we    = 1'b1;
                store_idx   = 5'd0;
            end else begin
                emit_v = 1'b1;
                case (b)
                    8'h2C:        emit_t.kind = K_COMMA;
                    8'h2E:        emit_t.kind = K_PERIOD;
                    8'h3B:        emit_t.kind = K_SEMI;
                    8'h29:        emit_t.kind = K_CLOSE;
                    8'h3D:        emit_t.kind = K_REL;
                    8'h2B, 8'h2D: emit_t.kind = K_ADD;
                    8'h2A:        emit_t.kind = K_MUL;
                    default:      halt_next   = 1'b1;
                endcase
            end
            if (emit_v) begin
                if (t0_v) begin
                    t1_v = 1'b1;
                    t1   = emit_t;
                end else begin
                    t0_v = 1'b1;
                    t0   = emit_t;
                end
            end
        end

        t0.last = !t1_v;
        t1.last = 1'b1;
    end

    assign tok0_valid = take && !halt_reg && t0_v;
    assign tok1_valid = take && !halt_reg && t1_v;
    assign tok0       = t0;
    assign tok1       = t1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            line_reg   <= 16'd1;
            pos_reg    <= 24'd0;
            tstart_reg <= 24'd0;
            len_reg    <= 5'd0;
            sline_reg  <= 16'd1;
            held_reg   <= 8'd0;
            halt_reg   <= 1'b0;
        end else if (take && !halt_reg) begin
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            pos_reg    <= pos_reg + 24'd1;
            tstart_reg <= tstart_next;
            len_reg    <= len_next;
            sline_reg  <= sline_next;
            held_reg   <= held_next;
            halt_reg   <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ID_LEN; i++) begin
            if (take && !halt_reg && store_we && store_idx == 5'(i)) begin
                store_reg[i] <= b;
            end
        end
    end

endmodule

FILE: rtl/core/lsx_tokq.sv
// Token queue and output side: takes up to two tokens a cycle, hands out one.
module lsx_tokq
    import lsx_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr0,
    input  logic   wr1,
    input  token_t data0,
    input  token_t data1,
    output logic   room,
    output logic   head_valid,
    output token_t head,
    input  logic   pop
);

    token_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] rd_reg, rd_next;
    logic [Q_PTR_W-1:0] wr_reg, wr_next;
    logic [Q_PTR_W:0]   cnt_reg, cnt_next;
    logic               do_pop;
    logic [Q_PTR_W:0]   n_wr;

    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_reg];
    assign room       = (cnt_reg <= (Q_PTR_W+1)'(Q_DEPTH - 2));
    assign do_pop     = pop && head_valid;
    assign n_wr       = (Q_PTR_W+1)'(wr0) + (Q_PTR_W+1)'(wr0 && wr1);
    assign rd_next    = rd_reg + Q_PTR_W'(do_pop);
    assign wr_next    = wr_reg + n_wr[Q_PTR_W-1:0];
    assign cnt_next   = cnt_reg + n_wr - (Q_PTR_W+1)'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0) begin
            slot_reg[wr_reg] <= data0;
        end
        if (wr0 && wr1) begin
            slot_reg[wr_reg + Q_PTR_W'(1)] <= data1;
        end
    end

endmodule

FILE: rtl/core/pascal_subset_lexer_unit.sv
// Top level: lexer scanner feeding a token queue and the output channel.
// A finished token is written into a queue slot register and is offered from the queue head.
// Throughput: one source byte per cycle while the queue has two free slots;
// tokens leave at one per cycle while token_ready is high, so a byte that yields two tokens costs a queue slot.
// Reset clears the scan state, counters and queue; the identifier store is not cleared.
module pascal_subset_lexer_unit
    import lsx_pkg::*;
#(
    parameter int MAX_ID_LEN = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        source_valid,
    output logic        source_ready,
    input  logic [7:0]  source_byte,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [4:0]  token_kind,
    output logic [15:0] token_line,
    output logic [23:0] token_offset,
    output logic [4:0]  token_length,
    output logic [7:0]  char_value,
    output logic        last_of_run
);

    logic   take;
    logic   tok0_valid, tok1_valid;
    token_t tok0, tok1;
    token_t head;

    assign take = source_valid && source_ready;

    lsx_scan #(
        .MAX_ID_LEN(MAX_ID_LEN)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .byte_in   (source_byte),
        .tok0_valid(tok0_valid),
        .tok1_valid(tok1_valid),
        .tok0      (tok0),
        .tok1      (tok1)
    );

    lsx_tokq u_tokq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr0       (tok0_valid),
        .wr1       (tok1_valid),
        .data0     (tok0),
        .data1     (tok1),
        .room      (source_ready),
        .head_valid(token_valid),
        .head      (head),
        .pop       (token_ready)
    );

    assign token_kind   = head.kind;
    assign token_line   = head.line;
    assign token_offset = head.offset;
    assign token_length = head.length;
    assign char_value   = head.char_value;
    assign last_of_run  = head.last;

endmodule
